/* rtl/i2cbs_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

  localparam int TICK_COUNT_BITS_DEF = 10;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_PHASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETUP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SETUP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_HOLD = 3'd5;

  localparam logic [CFG_W-1:0] RST_BUS_PHASE   = 10'd10;
  localparam logic [CFG_W-1:0] RST_CLOCK_HIGH  = 10'd20;
  localparam logic [CFG_W-1:0] RST_CLOCK_LOW   = 10'd20;
  localparam logic [CFG_W-1:0] RST_DATA_SETUP  = 10'd1;
  localparam logic [CFG_W-1:0] RST_READ_SETUP  = 10'd5;
  localparam logic [CFG_W-1:0] RST_SAMPLE_HOLD = 10'd1;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [3:0] BITS_PER_XFER = 4'd9;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ST_SCLHI  = 4'd1,
    PH_ST_SDALO  = 4'd2,
    PH_ST_SCLLO  = 4'd3,
    PH_ST_END    = 4'd4,
    PH_SP_SDALO  = 4'd5,
    PH_SP_SCLHI  = 4'd6,
    PH_SP_SDAHI  = 4'd7,
    PH_TX_SCLHI  = 4'd8,
    PH_TX_SCLLO  = 4'd9,
    PH_TX_END    = 4'd10,
    PH_RX_SCLHI  = 4'd11,
    PH_RX_SAMPLE = 4'd12,
    PH_RX_SCLLO  = 4'd13,
    PH_RX_END    = 4'd14
  } phase_t;

  typedef struct packed {
    phase_t          phase;
    logic [OP_W-1:0] kind;
    logic [3:0]      bits;
    logic [7:0]      shift;
    logic            ackh;
    logic            scl;
    logic            sda;
    logic            sen;
    logic            nack;
    logic [7:0]      rx;
    logic            done;
  } seq_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] bus_phase;
    logic [CFG_W-1:0] clock_high;
    logic [CFG_W-1:0] clock_low;
    logic [CFG_W-1:0] data_setup;
    logic [CFG_W-1:0] read_setup;
    logic [CFG_W-1:0] sample_hold;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/i2cbs_core.sv */
// ----------------------------------------------------------------------------
// i2cbs_core
// Applies one request to the sequencer state and runs at most one pin step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_core import i2cbs_pkg::*; #(
  parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
  input  seq_state_t                 st_i,
  input  logic [TICK_COUNT_BITS-1:0] wait_i,
  input  logic                       apply_i,
  input  logic [OP_W-1:0]            op_i,
  input  logic [7:0]                 data_i,
  input  logic                       ack_i,
  input  logic                       sample_i,
  input  cfg_t                       cfg_i,
  output seq_state_t                 st_o,
  output logic [TICK_COUNT_BITS-1:0] wait_o,
  output logic                       more_o,
  output logic                       rej_o
);

  localparam int SW = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;
  localparam logic [SW-1:0] LIM = SW'((64'd1 << TICK_COUNT_BITS) - 64'd1);

  function automatic logic [TICK_COUNT_BITS-1:0] sat(input logic [CFG_W-1:0] t);
    logic [SW-1:0] te;
    te = SW'(t);
    if (te > LIM) begin
      return TICK_COUNT_BITS'(LIM);
    end
    return TICK_COUNT_BITS'(te);
  endfunction

  function automatic seq_state_t next_bit(input seq_state_t s);
    seq_state_t r;
    r = s;
    if (s.kind == OP_WRITE) begin
      if (s.bits > 4'd1) begin
        r.sda   = s.shift[7];
        r.shift = {s.shift[6:0], 1'b0};
        r.sen   = 1'b1;
        r.phase = PH_TX_SCLHI;
      end else begin
        r.sen   = 1'b0;
        r.phase = PH_RX_SCLHI;
      end
    end else begin
      if (s.bits > 4'd1) begin
        r.sen   = 1'b0;
        r.phase = PH_RX_SCLHI;
      end else begin
        r.sda   = s.ackh;
        r.sen   = 1'b1;
        r.phase = PH_TX_SCLHI;
      end
    end
    return r;
  endfunction

  logic [TICK_COUNT_BITS-1:0] ld_bus, ld_hi, ld_lo, ld_ds, ld_rs, ld_sh;

  assign ld_bus = sat(cfg_i.bus_phase);
  assign ld_hi  = sat(cfg_i.clock_high);
  assign ld_lo  = sat(cfg_i.clock_low);
  assign ld_ds  = sat(cfg_i.data_setup);
  assign ld_rs  = sat(cfg_i.read_setup);
  assign ld_sh  = sat(cfg_i.sample_hold);

  seq_state_t                 s;
  logic [TICK_COUNT_BITS-1:0] w;
  logic                       rej;

  always_comb begin
    s   = st_i;
    w   = wait_i;
    rej = 1'b0;

    if (apply_i) begin
      s.done = 1'b0;
      unique case (op_i)
        OP_TICK: begin
          if (s.phase != PH_IDLE && w != '0) begin
            w = w - TICK_COUNT_BITS'(1);
          end
        end
        OP_START, OP_STOP, OP_WRITE, OP_READ: begin
          if (s.phase != PH_IDLE) begin
            rej = 1'b1;
          end else begin
            s.kind = op_i;
            unique case (op_i)
              OP_START: begin
                s.sda   = 1'b1;
                s.phase = PH_ST_SCLHI;
                w       = ld_bus;
              end
              OP_STOP: begin
                s.scl   = 1'b0;
                s.phase = PH_SP_SDALO;
                w       = ld_bus;
              end
              OP_WRITE: begin
                s.shift = data_i;
                s.bits  = BITS_PER_XFER;
                s       = next_bit(s);
                w       = (s.phase == PH_TX_SCLHI) ? ld_ds : ld_rs;
              end
              default: begin
                s.shift = 8'd0;
                s.ackh  = ack_i;
                s.bits  = BITS_PER_XFER;
                s       = next_bit(s);
                w       = (s.phase == PH_TX_SCLHI) ? ld_ds : ld_rs;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    if (s.phase != PH_IDLE && w == '0) begin
      unique case (s.phase)
        PH_ST_SCLHI: begin s.scl = 1'b1; w = ld_bus; s.phase = PH_ST_SDALO; end
        PH_ST_SDALO: begin s.sda = 1'b0; w = ld_bus; s.phase = PH_ST_SCLLO; end
        PH_ST_SCLLO: begin s.scl = 1'b0; w = ld_bus; s.phase = PH_ST_END; end
        PH_SP_SDALO: begin s.sda = 1'b0; w = ld_bus; s.phase = PH_SP_SCLHI; end
        PH_SP_SCLHI: begin s.scl = 1'b1; w = ld_bus; s.phase = PH_SP_SDAHI; end
        PH_SP_SDAHI: begin
          s.sda   = 1'b1;
          s.phase = PH_IDLE;
          w       = '0;
          s.bits  = 4'd0;
          s.done  = 1'b1;
        end
        PH_TX_SCLHI: begin s.scl = 1'b1; w = ld_hi; s.phase = PH_TX_SCLLO; end
        PH_TX_SCLLO: begin s.scl = 1'b0; w = ld_lo; s.phase = PH_TX_END; end
        PH_RX_SCLHI: begin s.scl = 1'b1; w = ld_hi; s.phase = PH_RX_SAMPLE; end
        PH_RX_SAMPLE: begin
          if (s.kind == OP_WRITE) begin
            s.nack = sample_i;
          end else begin
            s.shift = {s.shift[6:0], sample_i};
          end
          w       = ld_sh;
          s.phase = PH_RX_SCLLO;
        end
        PH_RX_SCLLO: begin s.scl = 1'b0; w = ld_lo; s.phase = PH_RX_END; end
        PH_TX_END, PH_RX_END: begin
          if (s.phase == PH_RX_END) begin
            s.sen = 1'b1;
          end
          if (s.bits != 4'd0) begin
            s.bits = s.bits - 4'd1;
          end
          if (s.kind == OP_READ && s.bits == 4'd1) begin
            s.rx = s.shift;
          end
          if (s.bits == 4'd0) begin
            s.phase = PH_IDLE;
            w       = '0;
            s.done  = 1'b1;
          end else begin
            s = next_bit(s);
            w = (s.phase == PH_TX_SCLHI) ? ld_ds : ld_rs;
          end
        end
        default: begin
          s.phase = PH_IDLE;
          w       = '0;
          s.bits  = 4'd0;
          s.done  = 1'b1;
        end
      endcase
    end
  end

  assign st_o   = s;
  assign wait_o = w;
  assign more_o = (s.phase != PH_IDLE) && (w == '0);
  assign rej_o  = rej;

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer driven by tick and command requests.
// ----------------------------------------------------------------------------
// Result: registered once an accepted request and any chained zero-wait pin
//   steps have run; each chained step is taken from the state register.
// Throughput: one request per cycle while every step wait is nonzero and no
//   output stall; the single-step core holds input for chained zero-wait steps.
// Reset: bus idle (SCL and SDA high, SDA driven), registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer import i2cbs_pkg::*; #(
  parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_ack_to_send,
  input  logic                 in_sda_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_scl_level,
  output logic                 out_sda_level,
  output logic                 out_sda_drive,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [7:0]           out_rx_byte,
  output logic                 out_nack,
  output logic                 out_rejected,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t                       cfg_r;
  seq_state_t                 st_r, st_nxt;
  logic [TICK_COUNT_BITS-1:0] wait_r, wait_nxt;
  logic                       drain_r, smp_r, rej_r;
  logic                       out_valid_r;
  logic                       o_scl_r, o_sda_r, o_sen_r, o_busy_r, o_done_r;
  logic [7:0]                 o_rx_r;
  logic                       o_nack_r, o_rej_r;

  logic slot_free, acc, step_en, more, rej_c, emit;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = drain_r || !slot_free;
  assign acc       = in_valid && !in_stall;
  assign step_en   = acc || (drain_r && slot_free);
  assign emit      = step_en && !more;
  assign cfg_ready = 1'b1;

  i2cbs_core #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_core (
    .st_i     (st_r),
    .wait_i   (wait_r),
    .apply_i  (acc),
    .op_i     (in_op),
    .data_i   (in_data_byte),
    .ack_i    (in_ack_to_send),
    .sample_i (acc ? in_sda_sample : smp_r),
    .cfg_i    (cfg_r),
    .st_o     (st_nxt),
    .wait_o   (wait_nxt),
    .more_o   (more),
    .rej_o    (rej_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_phase   <= RST_BUS_PHASE;
      cfg_r.clock_high  <= RST_CLOCK_HIGH;
      cfg_r.clock_low   <= RST_CLOCK_LOW;
      cfg_r.data_setup  <= RST_DATA_SETUP;
      cfg_r.read_setup  <= RST_READ_SETUP;
      cfg_r.sample_hold <= RST_SAMPLE_HOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUS_PHASE:   cfg_r.bus_phase   <= cfg_data;
        CFG_CLOCK_HIGH:  cfg_r.clock_high  <= cfg_data;
        CFG_CLOCK_LOW:   cfg_r.clock_low   <= cfg_data;
        CFG_DATA_SETUP:  cfg_r.data_setup  <= cfg_data;
        CFG_READ_SETUP:  cfg_r.read_setup  <= cfg_data;
        CFG_SAMPLE_HOLD: cfg_r.sample_hold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_IDLE;
      st_r.kind  <= '0;
      st_r.bits  <= '0;
      st_r.shift <= '0;
      st_r.ackh  <= 1'b0;
      st_r.scl   <= 1'b1;
      st_r.sda   <= 1'b1;
      st_r.sen   <= 1'b1;
      st_r.nack  <= 1'b0;
      st_r.rx    <= '0;
      st_r.done  <= 1'b0;
      wait_r     <= '0;
      drain_r    <= 1'b0;
      smp_r      <= 1'b0;
      rej_r      <= 1'b0;
    end else begin
      if (step_en) begin
        st_r    <= st_nxt;
        wait_r  <= wait_nxt;
        drain_r <= more;
      end
      if (acc) begin
        smp_r <= in_sda_sample;
        rej_r <= rej_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_scl_r  <= st_nxt.scl;
      o_sda_r  <= st_nxt.sda;
      o_sen_r  <= st_nxt.sen;
      o_busy_r <= st_nxt.phase != PH_IDLE;
      o_done_r <= st_nxt.done;
      o_rx_r   <= st_nxt.rx;
      o_nack_r <= st_nxt.nack;
      o_rej_r  <= acc ? rej_c : rej_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = o_scl_r;
  assign out_sda_level = o_sda_r;
  assign out_sda_drive = o_sen_r;
  assign out_busy_res  = o_busy_r;
  assign out_done_res  = o_done_r;
  assign out_rx_byte   = o_rx_r;
  assign out_nack      = o_nack_r;
  assign out_rejected  = o_rej_r;

  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (wait_r == '0))
    else $error("idle sequencer holds a pending wait");

  a_rest_has_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (!drain_r && st_r.phase != PH_IDLE) |-> (wait_r != '0))
    else $error("busy sequencer at rest with expired wait");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("finished request reported as busy");

  a_drain_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |=> (!$past(acc) || !$past(more)))
    else $error("request accepted during chained steps");

endmodule

`default_nettype wire
